/* src/smix_pkg.sv */
`timescale 1ns / 1ps

package smix_pkg;

    // operation codes carried in s_tuser
    typedef enum logic [1:0] {
        OP_TICK = 2'd0,
        OP_LOAD = 2'd1,
        OP_PLAY = 2'd2,
        OP_SEEK = 2'd3
    } op_t;

    // low two bits of the register index; bit 2 picks the deck
    typedef enum logic [1:0] {
        CFG_SPEED  = 2'd0,
        CFG_LOOP   = 2'd1,
        CFG_LENGTH = 2'd2,
        CFG_GAINS  = 2'd3
    } cfg_kind_t;

    // tick sequencer steps
    typedef enum logic [1:0] {
        PH_IDLE = 2'd0,
        PH_ADV  = 2'd1,
        PH_LOOP = 2'd2,
        PH_END  = 2'd3
    } phase_t;

    localparam int GAIN_FRAC  = 14;
    localparam int FIFO_DEPTH = 4;

    localparam logic [19:0]        SPEED_RESET = 20'd65536;
    localparam logic [17:0]        LOOP_GUARD  = 18'd1000;
    localparam logic signed [17:0] SAMPLE_MAX  = 18'sd32767;
    localparam logic signed [17:0] SAMPLE_MIN  = -18'sd32768;
    localparam logic signed [32:0] GAIN_ROUND  = 33'sd16383;

    typedef struct packed {
        logic [19:0] speed;
        logic        loop_en;
        logic [16:0] loop_in;
        logic [16:0] loop_end;
        logic [16:0] length;
        logic [15:0] gain0;
        logic [15:0] gain1;
    } deck_cfg_t;

    typedef struct packed {
        phase_t      phase;
        logic        seek;
        logic        play_wr;
        logic        play_val;
        logic [15:0] frame;
    } deck_ctl_t;

    // last field in the lowest bits
    typedef struct packed {
        logic               b_playing;
        logic               a_playing;
        logic signed [15:0] right;
        logic signed [15:0] left;
    } result_t;

    function automatic logic signed [15:0] clip16(input logic signed [17:0] v);
        if (v > SAMPLE_MAX)
            return SAMPLE_MAX[15:0];
        else if (v < SAMPLE_MIN)
            return SAMPLE_MIN[15:0];
        else
            return v[15:0];
    endfunction

endpackage

/* src/smix_bank.sv */
`timescale 1ns / 1ps

module smix_bank #(
    parameter int AW = 17
) (
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [31:0]   wdata,
    input  logic [AW-1:0] raddr_a,
    input  logic [AW-1:0] raddr_b,
    output logic [31:0]   rdata_a,
    output logic [31:0]   rdata_b
);

    logic [31:0] mem [0:(1 << AW) - 1];

    // one write port, two registered read ports, read returns old data on collision
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_a <= mem[raddr_a];
        rdata_b <= mem[raddr_b];
    end

endmodule

/* src/smix_deck.sv */
`timescale 1ns / 1ps

module smix_deck #(
    parameter int FRAMES = 65536
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  smix_pkg::deck_cfg_t          cfg,
    input  smix_pkg::deck_ctl_t          ctl,
    output logic [$clog2(FRAMES)-1:0]    frame,
    output logic                         frame_ok,
    output logic                         playing
);

    import smix_pkg::*;

    localparam int          FW         = $clog2(FRAMES);
    localparam logic [24:0] FRAMES_LIM = 25'(FRAMES);

    logic signed [40:0] ph_reg;
    logic signed [40:0] p_reg;
    logic signed [40:0] p_next;
    logic               playing_reg;
    logic [FW-1:0]      frame_reg;
    logic               ok_reg;

    logic signed [41:0] adv_sum;
    logic signed [41:0] jump_sum;
    logic signed [40:0] adv_sat;
    logic signed [40:0] jump_sat;
    logic signed [40:0] thr;
    logic signed [40:0] len_fp;
    logic [17:0]        lm;
    logic [17:0]        ld;
    logic               jump;
    logic               stop;
    logic [24:0]        fr_u;
    logic               fr_zero;
    logic               fr_ok;
    logic [FW-1:0]      fr_addr;

    // advance by speed, saturating at the top
    always_comb
    begin
        adv_sum = {ph_reg[40], ph_reg} + {22'd0, cfg.speed};
        if (adv_sum[41] != adv_sum[40])
            adv_sat = {1'b0, {40{1'b1}}};
        else
            adv_sat = adv_sum[40:0];
    end

    // loop test and jump, saturating both ways
    always_comb
    begin
        lm       = {1'b0, cfg.loop_end} - LOOP_GUARD;
        ld       = {1'b0, cfg.loop_in} - {1'b0, cfg.loop_end};
        thr      = {{7{lm[17]}}, lm, 16'd0};
        jump     = cfg.loop_en && (p_reg >= thr);
        jump_sum = {p_reg[40], p_reg} + {{8{ld[17]}}, ld, 16'd0};
        if (jump_sum[41] != jump_sum[40])
            jump_sat = jump_sum[41] ? {1'b1, 40'd0} : {1'b0, {40{1'b1}}};
        else
            jump_sat = jump_sum[40:0];
    end

    // end of track and frame lookup, frame truncated toward zero
    always_comb
    begin
        len_fp  = {8'd0, cfg.length, 16'd0};
        stop    = p_reg >= len_fp;
        fr_u    = p_reg[40:16];
        fr_zero = (p_reg[40:16] == '1) && (p_reg[15:0] != '0);
        fr_ok   = (!p_reg[40] && (fr_u < {8'd0, cfg.length}) && (fr_u < FRAMES_LIM))
                  || (fr_zero && (cfg.length != '0));
        fr_addr = p_reg[40] ? '0 : fr_u[FW-1:0];
    end

    // working playhead per step
    always_comb
    begin
        unique case (ctl.phase)
            PH_ADV:  p_next = adv_sat;
            PH_LOOP: p_next = jump ? jump_sat : p_reg;
            PH_IDLE: p_next = p_reg;
            PH_END:  p_next = p_reg;
        endcase
    end

    // playhead and play flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ph_reg      <= '0;
            playing_reg <= 1'b0;
        end
        else if (ctl.phase == PH_END)
        begin
            if (playing_reg)
            begin
                ph_reg <= p_reg;
                if (stop)
                begin
                    playing_reg <= 1'b0;
                end
            end
        end
        else
        begin
            if (ctl.seek)
            begin
                ph_reg <= {9'd0, ctl.frame, 16'd0};
            end
            if (ctl.play_wr)
            begin
                playing_reg <= ctl.play_val;
            end
        end
    end

    // working value and read address
    always_ff @(posedge clk)
    begin
        p_reg <= p_next;
        if (ctl.phase == PH_END)
        begin
            frame_reg <= fr_addr;
            ok_reg    <= playing_reg && fr_ok;
        end
    end

    assign frame    = frame_reg;
    assign frame_ok = ok_reg;
    assign playing  = playing_reg;

endmodule

/* src/smix_gain.sv */
`timescale 1ns / 1ps

module smix_gain (
    input  logic               clk,
    input  logic [31:0]        w0,
    input  logic [31:0]        w1,
    input  logic [15:0]        g0,
    input  logic [15:0]        g1,
    output logic signed [15:0] left,
    output logic signed [15:0] right
);

    import smix_pkg::*;

    logic signed [32:0] l0_reg;
    logic signed [32:0] r0_reg;
    logic signed [32:0] l1_reg;
    logic signed [32:0] r1_reg;
    logic signed [16:0] ge0;
    logic signed [16:0] ge1;
    logic signed [15:0] c_l0;
    logic signed [15:0] c_r0;
    logic signed [15:0] c_l1;
    logic signed [15:0] c_r1;
    logic signed [17:0] sum_l;
    logic signed [17:0] sum_r;

    // divide by 2^14 truncating toward zero, then clip
    function automatic logic signed [15:0] scale(input logic signed [32:0] p);
        logic signed [32:0] q;
        if (p < 0)
            q = (p + GAIN_ROUND) >>> GAIN_FRAC;
        else
            q = p >>> GAIN_FRAC;
        return clip16(q[17:0]);
    endfunction

    assign ge0 = {1'b0, g0};
    assign ge1 = {1'b0, g1};

    // products
    always_ff @(posedge clk)
    begin
        l0_reg <= $signed(w0[15:0]) * ge0;
        r0_reg <= $signed(w0[31:16]) * ge0;
        l1_reg <= $signed(w1[15:0]) * ge1;
        r1_reg <= $signed(w1[31:16]) * ge1;
    end

    // scale and stem sum
    always_comb
    begin
        c_l0  = scale(l0_reg);
        c_r0  = scale(r0_reg);
        c_l1  = scale(l1_reg);
        c_r1  = scale(r1_reg);
        sum_l = {{2{c_l0[15]}}, c_l0} + {{2{c_l1[15]}}, c_l1};
        sum_r = {{2{c_r0[15]}}, c_r0} + {{2{c_r1[15]}}, c_r1};
    end

    always_ff @(posedge clk)
    begin
        left  <= clip16(sum_l);
        right <= clip16(sum_r);
    end

endmodule

/* src/two_deck_stem_mixer.sv */
`timescale 1ns / 1ps

// channel   direction  beat contents
// s_*       in         tuser: operation; tdata: deck, stem, frame, left_in, right_in, play
// m_*       out        tdata: left_out, right_out, deck_a_playing, deck_b_playing
// cfg_*     in         register index and data, written on cfg_we
//
// load, play and seek are single beats; a tick holds off the input
// while the playhead sequencer advances, loops and end-checks both decks
// a tick result passes through the read, product and mix registers into a 4-beat output fifo
// beyond that, the input stalls when fifo beats plus ticks in flight reach 4
// samples live in two memories (one per stem), undefined until loaded

module two_deck_stem_mixer #(
    parameter int FRAMES = 65536
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [55:0] s_tdata,   // deck, stem, frame[15:0], left_in, right_in, play
    input  logic [1:0]  s_tuser,   // operation
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // left_out, right_out, deck_a_playing, deck_b_playing
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [34:0] cfg_data
);

    import smix_pkg::*;

    localparam int          FW         = $clog2(FRAMES);
    localparam int          AW         = FW + 1;
    localparam int          PTR_W      = $clog2(FIFO_DEPTH);
    localparam int          CNT_W      = $clog2(FIFO_DEPTH + 1);
    localparam logic [24:0] FRAMES_LIM = 25'(FRAMES);

    // input beat fields
    op_t                op;
    logic               in_deck;
    logic               in_stem;
    logic [15:0]        in_frame;
    logic [15:0]        in_left;
    logic [15:0]        in_right;
    logic               in_play;
    logic               accept;
    logic               tick_start;
    logic               room;

    deck_cfg_t          cfg_reg [2];
    phase_t             state_reg;
    phase_t             state_next;
    deck_ctl_t          ctl_a;
    deck_ctl_t          ctl_b;

    logic [FW-1:0]      frame_a;
    logic [FW-1:0]      frame_b;
    logic               ok_a;
    logic               ok_b;
    logic               playing_a;
    logic               playing_b;

    logic               ld_ok;
    logic [AW-1:0]      waddr;
    logic [31:0]        wdata;
    logic [31:0]        rd0_a;
    logic [31:0]        rd0_b;
    logic [31:0]        rd1_a;
    logic [31:0]        rd1_b;

    logic               rd_v_reg;
    logic               mul_v_reg;
    logic               sc_v_reg;
    logic               mix_v_reg;
    logic               ok_a_reg;
    logic               ok_b_reg;
    logic [1:0]         pl_mul_reg;
    logic [1:0]         pl_sc_reg;
    logic [1:0]         pl_mix_reg;

    logic signed [15:0] a_left;
    logic signed [15:0] a_right;
    logic signed [15:0] b_left;
    logic signed [15:0] b_right;
    result_t            res;

    result_t            fifo_mem [FIFO_DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg;
    logic [PTR_W-1:0]   rd_ptr_reg;
    logic [CNT_W-1:0]   cnt_reg;
    logic [CNT_W-1:0]   infl_reg;
    logic               push;
    logic               pop;

    // beat decode
    assign op       = op_t'(s_tuser);
    assign in_deck  = s_tdata[0];
    assign in_stem  = s_tdata[1];
    assign in_frame = s_tdata[17:2];
    assign in_left  = s_tdata[33:18];
    assign in_right = s_tdata[49:34];
    assign in_play  = s_tdata[50];

    assign room       = ({1'b0, cnt_reg} + {1'b0, infl_reg}) < (CNT_W + 1)'(FIFO_DEPTH);
    assign s_tready   = (state_reg == PH_IDLE) && room;
    assign accept     = s_tvalid && s_tready;
    assign tick_start = accept && (op == OP_TICK);

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg[0] <= '{speed: SPEED_RESET, default: '0};
            cfg_reg[1] <= '{speed: SPEED_RESET, default: '0};
        end
        else if (cfg_we)
        begin
            unique case (cfg_kind_t'(cfg_index[1:0]))
                CFG_SPEED:  cfg_reg[cfg_index[2]].speed <= cfg_data[19:0];
                CFG_LOOP:
                begin
                    cfg_reg[cfg_index[2]].loop_en  <= cfg_data[0];
                    cfg_reg[cfg_index[2]].loop_in  <= cfg_data[17:1];
                    cfg_reg[cfg_index[2]].loop_end <= cfg_data[34:18];
                end
                CFG_LENGTH: cfg_reg[cfg_index[2]].length <= cfg_data[16:0];
                CFG_GAINS:
                begin
                    cfg_reg[cfg_index[2]].gain0 <= cfg_data[15:0];
                    cfg_reg[cfg_index[2]].gain1 <= cfg_data[31:16];
                end
            endcase
        end
    end

    // tick sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= PH_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        unique case (state_reg)
            PH_IDLE: state_next = tick_start ? PH_ADV : PH_IDLE;
            PH_ADV:  state_next = PH_LOOP;
            PH_LOOP: state_next = PH_END;
            PH_END:  state_next = PH_IDLE;
        endcase

        ctl_a.phase    = state_reg;
        ctl_a.seek     = accept && (op == OP_SEEK) && !in_deck;
        ctl_a.play_wr  = accept && (op == OP_PLAY) && !in_deck;
        ctl_a.play_val = in_play;
        ctl_a.frame    = in_frame;

        ctl_b.phase    = state_reg;
        ctl_b.seek     = accept && (op == OP_SEEK) && in_deck;
        ctl_b.play_wr  = accept && (op == OP_PLAY) && in_deck;
        ctl_b.play_val = in_play;
        ctl_b.frame    = in_frame;
    end

    smix_deck #(.FRAMES(FRAMES)) u_deck_a (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg_reg[0]),
        .ctl      (ctl_a),
        .frame    (frame_a),
        .frame_ok (ok_a),
        .playing  (playing_a)
    );

    smix_deck #(.FRAMES(FRAMES)) u_deck_b (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg_reg[1]),
        .ctl      (ctl_b),
        .frame    (frame_b),
        .frame_ok (ok_b),
        .playing  (playing_b)
    );

    // sample memories, one per stem, addressed by deck and frame
    assign ld_ok = accept && (op == OP_LOAD) && ({9'd0, in_frame} < FRAMES_LIM);
    assign waddr = {in_deck, FW'(in_frame)};
    assign wdata = {in_right, in_left};

    smix_bank #(.AW(AW)) u_bank0 (
        .clk     (clk),
        .we      (ld_ok && !in_stem),
        .waddr   (waddr),
        .wdata   (wdata),
        .raddr_a ({1'b0, frame_a}),
        .raddr_b ({1'b1, frame_b}),
        .rdata_a (rd0_a),
        .rdata_b (rd0_b)
    );

    smix_bank #(.AW(AW)) u_bank1 (
        .clk     (clk),
        .we      (ld_ok && in_stem),
        .waddr   (waddr),
        .wdata   (wdata),
        .raddr_a ({1'b0, frame_a}),
        .raddr_b ({1'b1, frame_b}),
        .rdata_a (rd1_a),
        .rdata_b (rd1_b)
    );

    // result pipeline valids
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_v_reg  <= 1'b0;
            mul_v_reg <= 1'b0;
            sc_v_reg  <= 1'b0;
            mix_v_reg <= 1'b0;
        end
        else
        begin
            rd_v_reg  <= (state_reg == PH_END);
            mul_v_reg <= rd_v_reg;
            sc_v_reg  <= mul_v_reg;
            mix_v_reg <= sc_v_reg;
        end
    end

    // frame validity and play flags follow the samples
    always_ff @(posedge clk)
    begin
        ok_a_reg   <= ok_a;
        ok_b_reg   <= ok_b;
        pl_mul_reg <= {playing_b, playing_a};
        pl_sc_reg  <= pl_mul_reg;
        pl_mix_reg <= pl_sc_reg;
    end

    smix_gain u_gain_a (
        .clk   (clk),
        .w0    (ok_a_reg ? rd0_a : 32'd0),
        .w1    (ok_a_reg ? rd1_a : 32'd0),
        .g0    (cfg_reg[0].gain0),
        .g1    (cfg_reg[0].gain1),
        .left  (a_left),
        .right (a_right)
    );

    smix_gain u_gain_b (
        .clk   (clk),
        .w0    (ok_b_reg ? rd0_b : 32'd0),
        .w1    (ok_b_reg ? rd1_b : 32'd0),
        .g0    (cfg_reg[1].gain0),
        .g1    (cfg_reg[1].gain1),
        .left  (b_left),
        .right (b_right)
    );

    // deck sum and clip
    always_comb
    begin
        res.left      = clip16({{2{a_left[15]}}, a_left} + {{2{b_left[15]}}, b_left});
        res.right     = clip16({{2{a_right[15]}}, a_right} + {{2{b_right[15]}}, b_right});
        res.a_playing = pl_mix_reg[0];
        res.b_playing = pl_mix_reg[1];
    end

    // output fifo and in-flight count
    assign push = mix_v_reg;
    assign pop  = m_tvalid && m_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
            infl_reg   <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            cnt_reg  <= cnt_reg + CNT_W'(push) - CNT_W'(pop);
            infl_reg <= infl_reg + CNT_W'(tick_start) - CNT_W'(push);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            fifo_mem[wr_ptr_reg] <= res;
        end
    end

    assign m_tvalid = (cnt_reg != '0);
    assign m_tdata  = {6'd0, fifo_mem[rd_ptr_reg]};

endmodule

/* bench/mixer_monitor.sv */
`timescale 1ns / 1ps

module mixer_monitor #(
    parameter int FRAMES = 65536
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [55:0] s_tdata,   // deck, stem, frame[15:0], left_in, right_in, play
    input  logic [1:0]  s_tuser,   // operation
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [39:0] m_tdata,   // left_out, right_out, deck_a_playing, deck_b_playing
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [34:0] cfg_data,
    output int          mismatches,
    output int          pending
);

    import smix_pkg::*;

    localparam longint HEAD_MAX  = (longint'(1) << 40) - 1;
    localparam longint HEAD_MIN  = -(longint'(1) << 40);
    localparam longint FRAME_ONE = 65536;
    localparam longint LOOP_LEAD = 1000;

    // shadow of the mixer: registers, playheads, play flags and loaded samples
    deck_cfg_t   deck_cfg [2];
    longint      head [2];
    logic        running [2];
    logic [31:0] sample_mem [int];
    result_t     mix_queue [$];

    function automatic longint clamp_head(input longint v);
        if (v > HEAD_MAX)
            return HEAD_MAX;
        if (v < HEAD_MIN)
            return HEAD_MIN;
        return v;
    endfunction

    function automatic int sat16(input int v);
        if (v > 32767)
            return 32767;
        if (v < -32768)
            return -32768;
        return v;
    endfunction

    // unsigned q2.14 gain, truncated toward zero
    function automatic int scale(input logic signed [15:0] smp, input logic [15:0] gain);
        int prod;
        prod = int'(smp) * int'({16'd0, gain});
        return sat16(prod / 16384);
    endfunction

    // advance one deck by a tick and return its clipped stem mix
    function automatic void play_deck(input int d, output int mix_l, output int mix_r);
        longint      p;
        longint      fr;
        longint      lin;
        longint      lout;
        int          acc_l;
        int          acc_r;
        int          key;
        logic [31:0] word;
        logic [15:0] gain;
        mix_l = 0;
        mix_r = 0;
        acc_l = 0;
        acc_r = 0;
        if (!running[d])
            return;
        p = clamp_head(head[d] + longint'(deck_cfg[d].speed));
        if (deck_cfg[d].loop_en)
        begin
            lin  = longint'(deck_cfg[d].loop_in);
            lout = longint'(deck_cfg[d].loop_end);
            if (p >= (lout - LOOP_LEAD) * FRAME_ONE)
                p = clamp_head(p + (lin - lout) * FRAME_ONE);
        end
        if (p >= longint'(deck_cfg[d].length) * FRAME_ONE)
            running[d] = 1'b0;
        head[d] = p;
        // integer part, truncated toward zero
        fr = p / FRAME_ONE;
        if (fr < 0 || fr >= longint'(deck_cfg[d].length) || fr >= FRAMES)
            return;
        for (int s = 0; s < 2; s++)
        begin
            key  = (d * 2 + s) * FRAMES + int'(fr);
            word = sample_mem.exists(key) ? sample_mem[key] : 32'd0;
            gain = (s == 0) ? deck_cfg[d].gain0 : deck_cfg[d].gain1;
            acc_l += scale(word[15:0], gain);
            acc_r += scale(word[31:16], gain);
        end
        mix_l = sat16(acc_l);
        mix_r = sat16(acc_r);
    endfunction

    // one tick: both decks, then the deck sum clipped again
    function automatic result_t mix_tick();
        int      al;
        int      ar;
        int      bl;
        int      br;
        result_t r;
        play_deck(0, al, ar);
        play_deck(1, bl, br);
        r.left      = 16'(sat16(al + bl));
        r.right     = 16'(sat16(ar + br));
        r.a_playing = running[0];
        r.b_playing = running[1];
        return r;
    endfunction

    function automatic void check_field(input string name, input logic signed [16:0] want,
                                        input logic signed [16:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatches++;
        end
    endfunction

    // watch config writes, input beats and result beats
    always @(posedge clk or negedge rst_n)
    begin : watch
        int      d;
        int      key;
        result_t got;
        result_t want;
        if (!rst_n)
        begin
            for (int i = 0; i < 2; i++)
            begin
                deck_cfg[i]       = '0;
                deck_cfg[i].speed = SPEED_RESET;
                head[i]           = 0;
                running[i]        = 1'b0;
            end
            sample_mem.delete();
            mix_queue.delete();
            mismatches = 0;
        end
        else
        begin
            // register write
            if (cfg_we)
            begin
                d = int'(cfg_index[2]);
                case (cfg_kind_t'(cfg_index[1:0]))
                    CFG_SPEED:
                        deck_cfg[d].speed = cfg_data[19:0];
                    CFG_LOOP:
                    begin
                        deck_cfg[d].loop_en  = cfg_data[0];
                        deck_cfg[d].loop_in  = cfg_data[17:1];
                        deck_cfg[d].loop_end = cfg_data[34:18];
                    end
                    CFG_LENGTH:
                        deck_cfg[d].length = cfg_data[16:0];
                    default:
                    begin
                        deck_cfg[d].gain0 = cfg_data[15:0];
                        deck_cfg[d].gain1 = cfg_data[31:16];
                    end
                endcase
            end

            // result beat against the oldest predicted mix
            if (m_tvalid && m_tready)
            begin
                got = result_t'(m_tdata[33:0]);
                if (mix_queue.size() == 0)
                begin
                    $error("result beat with no tick outstanding: %h", m_tdata);
                    mismatches++;
                end
                else
                begin
                    want = mix_queue.pop_front();
                    check_field("left_out", want.left, got.left);
                    check_field("right_out", want.right, got.right);
                    check_field("deck_a_playing", want.a_playing, got.a_playing);
                    check_field("deck_b_playing", want.b_playing, got.b_playing);
                end
            end

            // input beat
            if (s_tvalid && s_tready)
            begin
                d = int'(s_tdata[0]);
                case (op_t'(s_tuser))
                    OP_TICK:
                        mix_queue.insert(mix_queue.size(), mix_tick());
                    OP_LOAD:
                    begin
                        key = int'({s_tdata[0], s_tdata[1]}) * FRAMES + int'(s_tdata[17:2]);
                        if (int'(s_tdata[17:2]) < FRAMES)
                            sample_mem[key] = {s_tdata[49:34], s_tdata[33:18]};
                    end
                    OP_PLAY:
                        running[d] = s_tdata[50];
                    default:
                        head[d] = longint'(s_tdata[17:2]) * FRAME_ONE;
                endcase
            end
        end
        pending = mix_queue.size();
    end

endmodule

/* bench/tb_top.sv */
`timescale 1ns / 1ps

module tb_top;
    import smix_pkg::*;

    localparam int HOLD_SETTLE   = 20;
    localparam int CYCLE_LIMIT   = 500000;
    localparam int LOW_SPAN      = 64;
    localparam int HIGH_BASE     = 65520;
    localparam int RANDOM_PHASES = 16;
    localparam int PHASE_BEATS   = 57;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [55:0] s_tdata;   // deck, stem, frame[15:0], left_in, right_in, play
    logic [1:0]  s_tuser;   // operation
    logic        m_tvalid;
    logic        m_tready;
    logic [39:0] m_tdata;   // left_out, right_out, deck_a_playing, deck_b_playing
    logic        cfg_we;
    logic [2:0]  cfg_index;
    logic [34:0] cfg_data;
    int          mismatches;
    int          pending;
    int          cycles = 0;
    logic        feed_burst = 1'b0;
    logic        drain_burst = 1'b0;

    always #4 clk = ~clk;

    two_deck_stem_mixer u_top (.*);

    mixer_monitor u_monitor (.*);

    // watchdog
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // result sink with random stalls and stall-free stretches
    initial
    begin : sink
        int stall;
        m_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if ($urandom_range(0, 39) == 0)
                drain_burst = !drain_burst;
            stall = drain_burst ? 0 : $urandom_range(0, 14);
            if (stall > 0)
            begin
                m_tready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            m_tready <= 1'b1;
            do @(posedge clk); while (!m_tvalid);
        end
    end

    function automatic logic [15:0] pick_sample();
        case ($urandom_range(0, 5))
            0:       return 16'h8000;
            1:       return 16'h7FFF;
            2:       return 16'h0000;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [15:0] pick_gain();
        case ($urandom_range(0, 3))
            0:       return 16'h0000;
            1:       return 16'h4000;
            2:       return 16'hFFFF;
            default: return 16'($urandom);
        endcase
    endfunction

    // long tracks keep every playhead inside the loaded top window
    function automatic logic [15:0] seek_target(input logic long_track);
        if (long_track)
            return 16'($urandom_range(HIGH_BASE, 65535));
        if ($urandom_range(0, 1) == 0)
            return 16'($urandom_range(0, LOW_SPAN + 8));
        return 16'($urandom);
    endfunction

    // one input beat after a random gap
    task automatic send_beat(input op_t op, input logic deck, input logic stem,
                             input logic [15:0] frame, input logic [15:0] left,
                             input logic [15:0] right, input logic play);
        int gap;
        if ($urandom_range(0, 39) == 0)
            feed_burst = !feed_burst;
        gap = feed_burst ? 0 : $urandom_range(0, 14);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {5'd0, play, right, left, frame, stem, deck};
        do @(posedge clk); while (!s_tready);
        @(negedge clk);
    endtask

    task automatic do_tick();
        send_beat(OP_TICK, 1'($urandom), 1'($urandom), 16'($urandom), 16'($urandom),
                  16'($urandom), 1'($urandom));
    endtask

    task automatic do_load(input logic d, input logic s, input logic [15:0] frame,
                           input logic [15:0] left, input logic [15:0] right);
        send_beat(OP_LOAD, d, s, frame, left, right, 1'($urandom));
    endtask

    task automatic do_play(input logic d, input logic on);
        send_beat(OP_PLAY, d, 1'($urandom), 16'($urandom), 16'($urandom), 16'($urandom), on);
    endtask

    task automatic do_seek(input logic d, input logic [15:0] frame);
        send_beat(OP_SEEK, d, 1'($urandom), frame, 16'($urandom), 16'($urandom),
                  1'($urandom));
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [34:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(negedge clk);
        cfg_we    <= 1'b0;
        @(negedge clk);
    endtask

    task automatic setup_deck(input logic d, input logic [19:0] speed, input logic en,
                              input logic [16:0] lin, input logic [16:0] lout,
                              input logic [16:0] len, input logic [15:0] g0,
                              input logic [15:0] g1);
        write_reg({d, CFG_SPEED}, 35'(speed));
        write_reg({d, CFG_LOOP}, {lout, lin, en});
        write_reg({d, CFG_LENGTH}, 35'(len));
        write_reg({d, CFG_GAINS}, 35'({g1, g0}));
    endtask

    // drain every expected mix, then let a tick in flight settle
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (HOLD_SETTLE) @(negedge clk);
    endtask

    task automatic shuffle_deck(input logic d, input logic long_track);
        logic [19:0] speed;
        logic        en;
        logic [16:0] lin;
        logic [16:0] lout;
        logic [16:0] len;
        case ($urandom_range(0, 4))
            0:       speed = 20'd0;
            1:       speed = 20'd524288;
            2:       speed = 20'd65536;
            3:       speed = 20'($urandom_range(0, 131072));
            default: speed = 20'($urandom_range(0, 524288));
        endcase
        if (long_track)
        begin
            // equal loop points: the jump is zero
            en   = 1'($urandom);
            lin  = 17'($urandom);
            lout = lin;
            case ($urandom_range(0, 2))
                0:       len = 17'd65536;
                1:       len = 17'd65535;
                default: len = 17'($urandom_range(HIGH_BASE - 16, 65536));
            endcase
        end
        else
        begin
            case ($urandom_range(0, 2))
                0:       len = 17'd0;
                1:       len = 17'(LOW_SPAN);
                default: len = 17'($urandom_range(1, LOW_SPAN));
            endcase
            case ($urandom_range(0, 3))
                0:
                begin
                    en   = 1'b0;
                    lin  = 17'($urandom);
                    lout = 17'($urandom);
                end
                // loop that stays inside a short track
                1:
                begin
                    en   = 1'b1;
                    lin  = 17'(1000 + $urandom_range(0, LOW_SPAN - 1));
                    lout = 17'(1000 + $urandom_range(1, LOW_SPAN));
                end
                // loop out below the lead: the loop threshold is below frame zero
                2:
                begin
                    en   = 1'b1;
                    lin  = 17'($urandom_range(0, 1100));
                    lout = 17'($urandom_range(0, 999));
                end
                default:
                begin
                    en   = 1'b1;
                    lin  = $urandom_range(0, 1) ? 17'($urandom) : {17{1'($urandom)}};
                    lout = $urandom_range(0, 1) ? 17'($urandom) : {17{1'($urandom)}};
                end
            endcase
        end
        setup_deck(d, speed, en, lin, lout, len, pick_gain(), pick_gain());
    endtask

    task automatic random_phase(input logic long_track);
        logic d;
        wait_idle();
        shuffle_deck(1'b0, long_track);
        shuffle_deck(1'b1, long_track);
        for (int i = 0; i < 2; i++)
        begin
            do_seek(1'(i), seek_target(long_track));
            do_play(1'(i), 1'b1);
        end
        repeat (PHASE_BEATS)
        begin
            d = 1'($urandom);
            case ($urandom_range(0, 19))
                0, 1, 2:
                    do_load(d, 1'($urandom),
                            $urandom_range(0, 1) ? 16'($urandom_range(0, LOW_SPAN - 1))
                                                 : 16'($urandom),
                            pick_sample(), pick_sample());
                3, 4:
                    do_play(d, $urandom_range(0, 3) != 0);
                5, 6:
                    do_seek(d, seek_target(long_track));
                default:
                    do_tick();
            endcase
        end
    endtask

    initial
    begin
        rst_n     = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tuser   = OP_TICK;
        cfg_we    = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        repeat (2) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // deck a plain at unit speed, deck b half speed with a one-frame back jump
        setup_deck(1'b0, 20'd65536, 1'b0, 17'd0, 17'd0, 17'(LOW_SPAN), 16'hFFFF, 16'h4000);
        setup_deck(1'b1, 20'h08000, 1'b1, 17'd0, 17'd1, 17'(LOW_SPAN), 16'h4000, 16'h0000);

        // fill the bottom and top windows of every stem
        for (int k = 0; k < 4; k++)
        begin
            for (int f = 0; f < LOW_SPAN; f++)
                do_load(1'(k >> 1), 1'(k), 16'(f), pick_sample(), pick_sample());
            for (int f = HIGH_BASE; f < 65536; f++)
                do_load(1'(k >> 1), 1'(k), 16'(f), pick_sample(), pick_sample());
        end

        // both decks running; deck b passes through a playhead in (-1, 0)
        do_seek(1'b0, 16'd0);
        do_seek(1'b1, 16'd0);
        do_play(1'b0, 1'b1);
        do_play(1'b1, 1'b1);
        repeat (3) do_tick();
        // full-scale samples against the largest gain
        do_load(1'b0, 1'b0, 16'd5, 16'h7FFF, 16'h8000);
        do_load(1'b0, 1'b1, 16'd5, 16'h7FFF, 16'h8000);
        do_seek(1'b0, 16'd4);
        do_tick();
        // end of track stops the deck, then a stopped deck holds still
        do_seek(1'b0, 16'(LOW_SPAN - 1));
        do_tick();
        do_tick();
        do_play(1'b0, 1'b1);
        do_seek(1'b0, 16'(LOW_SPAN - 2));
        do_tick();
        do_play(1'b1, 1'b0);
        do_tick();
        // top frame address, beyond the track length
        do_load(1'b1, 1'b0, 16'hFFFF, 16'h8000, 16'h7FFF);
        do_seek(1'b1, 16'hFFFF);
        do_play(1'b1, 1'b1);
        do_tick();
        do_play(1'b0, 1'b0);
        do_tick();

        // playhead runs into its upper bound: restart and jump forward each tick
        wait_idle();
        setup_deck(1'b0, 20'd524288, 1'b1, 17'h1FFFF, 17'd0, 17'(LOW_SPAN),
                   16'h4000, 16'h4000);
        setup_deck(1'b1, 20'd0, 1'b0, 17'd0, 17'd0, 17'd0, 16'h0000, 16'h0000);
        repeat (140)
        begin
            do_play(1'b0, 1'b1);
            do_tick();
        end

        // random phases, every fourth one on a full-length track
        for (int ph = 0; ph < RANDOM_PHASES; ph++)
            random_phase((ph % 4) == 3);

        wait_idle();
        if (mismatches == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

/* sim.f */
src/smix_pkg.sv
src/smix_bank.sv
src/smix_deck.sv
src/smix_gain.sv
src/two_deck_stem_mixer.sv
bench/mixer_monitor.sv
bench/tb_top.sv
